@@ hdl/seconds_to_calendar_weekday_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the seconds-to-calendar unit
// Shared assertion forms, clocked on clock and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SECONDS_TO_CALENDAR_WEEKDAY_UNIT_DEFINES_SVH
`define SECONDS_TO_CALENDAR_WEEKDAY_UNIT_DEFINES_SVH

// same-cycle implication
`define S2CW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define S2CW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/s2cw_pkg.sv @@
// ----------------------------------------------------------------------------
// s2cw_pkg
// Types, constants and small calendar helpers for the seconds-to-calendar unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package s2cw_pkg;

   localparam int unsigned SecsPerDay  = 86400;
   localparam int unsigned SecsPerHour = 3600;
   localparam int unsigned SecsPerMin  = 60;
   localparam int unsigned BaseYear    = 2000;
   localparam int unsigned DaysYear    = 365;
   localparam int unsigned DaysLeap    = 366;
   localparam int unsigned LastMonth   = 11;   // December, zero based
   localparam int unsigned CenturyOff  = 100;  // 2100: the only non-leap year divisible by 4

   localparam int unsigned OpW = 18;

   typedef logic [OpW-1:0] opnd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_DAY,
      ST_YEAR,
      ST_MONTH,
      ST_HOUR,
      ST_MIN,
      ST_FINISH
   } state_type;

   // Year offset from 2000 covers 2000..2136; 2000 is a leap century.
   function automatic logic is_leap(logic [7:0] yoff);
      return (yoff[1:0] == 2'b00) && (yoff != 8'(CenturyOff));
   endfunction

   function automatic logic [4:0] month_len(logic [3:0] mon, logic leap);
      logic [4:0] len;
      case (mon)
         4'd1:                    len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   // days mod 7 -> weekday; day zero (2000-01-01) was a Saturday
   function automatic logic [2:0] weekday_of(logic [2:0] days_mod7);
      logic [3:0] v;
      v = {1'b0, days_mod7} + 4'd6;
      return (v >= 4'd7) ? 3'(v - 4'd7) : v[2:0];
   endfunction

endpackage

@@ hdl/seconds_to_calendar_weekday_unit.sv @@
// ----------------------------------------------------------------------------
// seconds_to_calendar_weekday_unit
// Converts seconds since 2000-01-01 00:00:00 into date, time and weekday.
// ----------------------------------------------------------------------------
// One item at a time, every arithmetic step through one shared
// subtract/compare unit: restoring division by 86400 (days and
// second-of-day, weekday tracked as days mod 7 on the fly), a walk over
// the years, a walk over the months, restoring division by 3600 for
// hours and by 60 for minutes, then a load into the result register.
// req_tready is high only while the sequencer is idle; the result register
// lets the next item start while the last result waits on rsp_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "seconds_to_calendar_weekday_unit_defines.svh"

module seconds_to_calendar_weekday_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seconds_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hours,
   // [31:26] minutes, [37:32] seconds, [40:38] weekday, [47:41] zero
   output logic [47:0] rsp_tdata
);
   import s2cw_pkg::*;

   state_type   state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [16:0] rem_ff, rem_in;     // partial remainder, then second-of-day
   logic [15:0] low_ff, low_in;     // low input bits, then day count
   logic [2:0]  wd_ff, wd_in;       // days mod 7
   logic [7:0]  yoff_ff, yoff_in;
   logic [3:0]  mon_ff, mon_in;
   logic [4:0]  hours_ff, hours_in;
   logic [5:0]  min_ff, min_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;

   opnd_type    op_a, op_b, diff;
   logic        ge;
   logic        leap;
   logic [3:0]  wd_step;
   logic [11:0] year_out;

   s2cw_sub_unit u_sub (
      .op_a (op_a),
      .op_b (op_b),
      .diff (diff),
      .ge   (ge)
   );

   assign leap     = is_leap(yoff_ff);
   assign wd_step  = {wd_ff, ge};
   assign year_out = 12'(BaseYear) + {4'b0, yoff_ff};

   // operand select for the shared unit
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_DIV_DAY: begin
            op_a = {rem_ff, low_ff[15]};
            op_b = OpW'(SecsPerDay);
         end
         ST_YEAR: begin
            op_a = {2'b0, low_ff};
            op_b = leap ? OpW'(DaysLeap) : OpW'(DaysYear);
         end
         ST_MONTH: begin
            op_a = {2'b0, low_ff};
            op_b = {13'b0, month_len(mon_ff, leap)};
         end
         ST_HOUR: begin
            op_a = {1'b0, rem_ff};
            op_b = OpW'(SecsPerHour) << cnt_ff;
         end
         ST_MIN: begin
            op_a = {1'b0, rem_ff};
            op_b = OpW'(SecsPerMin) << cnt_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      wd_in        = wd_ff;
      yoff_in      = yoff_ff;
      mon_in       = mon_ff;
      hours_in     = hours_ff;
      min_in       = min_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rem_in   = {1'b0, req_tdata[31:16]};
               low_in   = req_tdata[15:0];
               cnt_in   = 4'd15;
               wd_in    = '0;
               yoff_in  = '0;
               mon_in   = '0;
               hours_in = '0;
               min_in   = '0;
               state_in = ST_DIV_DAY;
            end
         end
         ST_DIV_DAY: begin
            // quotient bits shift into low_ff as the dividend bits shift out
            rem_in = ge ? diff[16:0] : {rem_ff[15:0], low_ff[15]};
            low_in = {low_ff[14:0], ge};
            wd_in  = (wd_step >= 4'd7) ? 3'(wd_step - 4'd7) : wd_step[2:0];
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (ge) begin
               low_in  = diff[15:0];
               yoff_in = yoff_ff + 8'd1;
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (ge && (mon_ff != 4'(LastMonth))) begin
               low_in = diff[15:0];
               mon_in = mon_ff + 4'd1;
            end else begin
               cnt_in   = 4'd4;
               state_in = ST_HOUR;
            end
         end
         ST_HOUR: begin
            if (ge) begin
               rem_in = diff[16:0];
            end
            hours_in = {hours_ff[3:0], ge};
            cnt_in   = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               cnt_in   = 4'd5;
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            if (ge) begin
               rem_in = diff[16:0];
            end
            min_in = {min_ff[4:0], ge};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, weekday_of(wd_ff), rem_ff[5:0], min_ff, hours_ff,
                               low_ff[4:0] + 5'd1, mon_ff + 4'd1, year_out};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      wd_ff       <= wd_in;
      yoff_ff     <= yoff_in;
      mon_ff      <= mon_in;
      hours_ff    <= hours_in;
      min_ff      <= min_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `S2CW_ASSERT_NEXT(a_accept_starts_div, req_tvalid && req_tready,
      state_ff == ST_DIV_DAY && cnt_ff == 4'd15,
      "accepted item did not start the day division")
   `S2CW_ASSERT_NEXT(a_finish_loads_rsp,
      state_ff == ST_FINISH && (!rsp_valid_ff || rsp_tready),
      rsp_tvalid && state_ff == ST_IDLE,
      "finished item not loaded into result register")
   `S2CW_ASSERT_NOW(a_month_range, state_ff != ST_IDLE && state_ff != ST_DIV_DAY,
      mon_ff <= 4'(LastMonth), "month walk ran past December")
   `S2CW_ASSERT_NOW(a_year_range, state_ff == ST_MONTH, yoff_ff <= 8'd136,
      "year walk ran past 2136")
   `S2CW_ASSERT_NOW(a_sod_range, state_ff == ST_YEAR, rem_ff < 17'(SecsPerDay),
      "second-of-day out of range after division")

endmodule

@@ hdl/s2cw_sub_unit.sv @@
// ----------------------------------------------------------------------------
// s2cw_sub_unit
// Shared subtract-and-compare unit used by every arithmetic step of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2cw_sub_unit (
   input  s2cw_pkg::opnd_type op_a,
   input  s2cw_pkg::opnd_type op_b,
   output s2cw_pkg::opnd_type diff,
   output logic               ge
);
   import s2cw_pkg::*;

   logic [OpW:0] full;

   assign full = {1'b0, op_a} - {1'b0, op_b};
   assign diff = full[OpW-1:0];
   assign ge   = ~full[OpW];

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for seconds_to_calendar_weekday_unit: a queue-fed
// stream driver, a response monitor and an in-bench calendar decoder that
// predicts date, time of day and weekday for every accepted item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import s2cw_pkg::SecsPerDay;
   import s2cw_pkg::SecsPerHour;
   import s2cw_pkg::SecsPerMin;
   import s2cw_pkg::BaseYear;
   import s2cw_pkg::DaysYear;
   import s2cw_pkg::DaysLeap;

   localparam int unsigned RandomItems = 550;
   localparam int unsigned MaxReports  = 10;
   localparam int unsigned DrainCycles = 250;

   localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // result layout, last member in the lowest bits
   typedef struct packed {
      logic [6:0]  pad;
      logic [2:0]  weekday;
      logic [5:0]  seconds;
      logic [5:0]  minutes;
      logic [4:0]  hours;
      logic [4:0]  day_of_month;
      logic [3:0]  month;
      logic [11:0] year;
   } date_time_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] seconds_count
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hours,
   // [31:26] minutes, [37:32] seconds, [40:38] weekday, [47:41] zero
   logic [47:0] rsp_tdata;

   logic [31:0]    pending_seconds [$];
   date_time_type  expected_dates [$];
   date_time_type  want_date, got_date;
   int unsigned    items_queued = 0;
   int unsigned    items_accepted = 0;
   int unsigned    failures = 0;
   int unsigned    send_gap = 0;
   int unsigned    hold_left = 0;
   bit             req_taken = 1'b0;
   bit             rsp_taken = 1'b0;
   bit             calm = 1'b0;

   seconds_to_calendar_weekday_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic date_time_type calendar_of(logic [31:0] secs);
      int unsigned days, sod, yr, mon, len, c, yy, m, d, t;
      date_time_type r;
      days = secs / SecsPerDay;
      sod  = secs % SecsPerDay;
      yr   = BaseYear;
      mon  = 0;
      while (1) begin
         len = leap_year(yr) ? DaysLeap : DaysYear;
         if (days < len) break;
         days -= len;
         yr++;
      end
      while (mon < 11) begin
         len = (mon == 1 && leap_year(yr)) ? 29 : MonthDays[mon];
         if (days < len) break;
         days -= len;
         mon++;
      end
      d = days + 1;
      // Zeller: January and February count as months 13 and 14 of the prior year
      if (mon + 1 <= 2) begin
         c  = (yr - 1) / 100;
         yy = (yr - 1) % 100;
         m  = mon + 13;
      end else begin
         c  = yr / 100;
         yy = yr % 100;
         m  = mon + 1;
      end
      t = yy + yy / 4 + c / 4 + (26 * (m + 1)) / 10 + d + 70 - 1 - 2 * c;
      r.pad          = '0;
      r.weekday      = 3'(t % 7);
      r.seconds      = 6'(sod % SecsPerMin);
      r.minutes      = 6'((sod % SecsPerHour) / SecsPerMin);
      r.hours        = 5'(sod / SecsPerHour);
      r.day_of_month = 5'(d);
      r.month        = 4'(mon + 1);
      r.year         = 12'(yr);
      return r;
   endfunction

   // mostly short gaps, a few long ones, none at all while calm
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(20, 250);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_seconds.size() > 0) begin
            req_tdata  <= pending_seconds.pop_front();
            req_tvalid <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_taken) hold_left = pick_gap();
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && req_tvalid && req_tready) begin
         expected_dates.push_back(calendar_of(req_tdata));
         items_accepted++;
         if (items_accepted % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_date = date_time_type'(rsp_tdata);
         if (expected_dates.size() == 0) begin
            failures++;
            if (failures <= MaxReports)
               $display("unexpected result item: %h", rsp_tdata);
         end else begin
            want_date = expected_dates.pop_front();
            if (got_date != want_date) begin
               failures++;
               if (failures <= MaxReports) begin
                  $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d wd %0d pad %h",
                           want_date.year, want_date.month, want_date.day_of_month,
                           want_date.hours, want_date.minutes, want_date.seconds,
                           want_date.weekday, want_date.pad);
                  $display("          got      %0d-%0d-%0d %0d:%0d:%0d wd %0d pad %h",
                           got_date.year, got_date.month, got_date.day_of_month,
                           got_date.hours, got_date.minutes, got_date.seconds,
                           got_date.weekday, got_date.pad);
               end
            end
         end
      end
   end

   initial begin
      longint unsigned year_days, secs;
      int unsigned     yoff;

      // day zero first, then day and year edges, leap day, 2100 non-leap
      pending_seconds = '{32'd0, 32'd59, 32'd3599, 32'd86399, 32'd86400,
                          32'd5097600, 32'd5184000, 32'd31536000, 32'd31622399,
                          32'd31622400, 32'd63072000, 32'd63158399,
                          32'd3061065600, 32'd3061151999, 32'd3061152000,
                          32'd3160771200, 32'd3160857600, 32'd3155759999,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF};

      for (int unsigned i = 0; i < RandomItems; i++) begin
         yoff = $urandom_range(0, 136);
         year_days = 0;
         for (int unsigned y = BaseYear; y < BaseYear + yoff; y++)
            year_days += leap_year(y) ? DaysLeap : DaysYear;
         case ($urandom_range(0, 3))
            0, 1: secs = $urandom;
            // around a new year
            2: secs = year_days * SecsPerDay + $urandom_range(0, 3 * SecsPerDay)
                      - ((yoff > 0) ? 2 * SecsPerDay : 0);
            // start or end of a random day in the year
            default: secs = (year_days + $urandom_range(0, 365)) * SecsPerDay
                            + ($urandom_range(0, 1) ? $urandom_range(0, 59)
                                                    : SecsPerDay - 1 - $urandom_range(0, 59));
         endcase
         if (secs > 64'hFFFF_FFFF) secs = $urandom;
         pending_seconds.push_back(32'(secs));
      end
      items_queued = pending_seconds.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(items_accepted == items_queued && expected_dates.size() == 0))
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
